/* src/three_level_priority_job_queue_unit_defines.svh */
// ---------------------------------------------------------------------------
// Three-level priority job queue: assertion macros
// Shared property templates for the checker of the job queue unit.
// ---------------------------------------------------------------------------
`ifndef THREE_LEVEL_PRIORITY_JOB_QUEUE_UNIT_DEFINES_SVH
`define THREE_LEVEL_PRIORITY_JOB_QUEUE_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TPJQ_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TPJQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/tpjq_pkg.sv */
// ---------------------------------------------------------------------------
// Three-level priority job queue: package
// Field widths, operation, level and status codes for the interfaces, unit, checker and testbench.
// ---------------------------------------------------------------------------
`default_nettype none

package tpjq_pkg;

    localparam int KIND_W    = 2;
    localparam int TAG_W     = 16;
    localparam int LEVEL_W   = 2;
    localparam int STATUS_W  = 2;
    localparam int PENDING_W = 6;

    typedef logic [KIND_W-1:0]    t_kind;
    typedef logic [TAG_W-1:0]     t_tag;
    typedef logic [LEVEL_W-1:0]   t_level;
    typedef logic [STATUS_W-1:0]  t_status;
    typedef logic [PENDING_W-1:0] t_pending;

    localparam t_kind KIND_PUSH  = 2'd0;
    localparam t_kind KIND_POP   = 2'd1;
    localparam t_kind KIND_CLEAR = 2'd2;

    localparam t_level LEVEL_HIGH   = 2'd0;
    localparam t_level LEVEL_NORMAL = 2'd1;
    localparam t_level LEVEL_LOW    = 2'd2;

    localparam t_status STATUS_DONE  = 2'd0;
    localparam t_status STATUS_FULL  = 2'd1;
    localparam t_status STATUS_EMPTY = 2'd2;

    localparam t_pending PENDING_MAX = 6'd63;

endpackage

`default_nettype wire

/* src/tpjq_if.sv */
// ---------------------------------------------------------------------------
// Three-level priority job queue: channel interfaces
// Valid/ready channels for job operations and for their results.
// ---------------------------------------------------------------------------
`default_nettype none

interface tpjq_job_if;
    import tpjq_pkg::*;

    logic   valid;
    logic   ready;
    t_kind  kind;
    t_tag   job_tag;
    t_level priority_req;

    modport source (output valid, output kind, output job_tag, output priority_req,
                    input ready);
    modport sink   (input valid, input kind, input job_tag, input priority_req,
                    output ready);
endinterface

interface tpjq_result_if;
    import tpjq_pkg::*;

    logic     valid;
    logic     ready;
    t_status  status;
    t_tag     popped_tag;
    t_level   popped_level;
    t_pending pending_count;

    modport source (output valid, output status, output popped_tag, output popped_level,
                    output pending_count, input ready);
    modport sink   (input valid, input status, input popped_tag, input popped_level,
                    input pending_count, output ready);
endinterface

`default_nettype wire

/* src/tpjq_tag_ram.sv */
// ---------------------------------------------------------------------------
// Three-level priority job queue: tag memory
// Simple dual-port synchronous RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
`default_nettype none

module tpjq_tag_ram #(
    parameter int ADDR_BITS = 6,
    parameter int DATA_BITS = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_wr_en,
    input  wire logic [ADDR_BITS-1:0] i_wr_addr,
    input  wire logic [DATA_BITS-1:0] i_wr_data,
    input  wire logic                 i_rd_en,
    input  wire logic [ADDR_BITS-1:0] i_rd_addr,
    output logic      [DATA_BITS-1:0] o_rd_data
);

    localparam int DEPTH = 1 << ADDR_BITS;

    logic [DATA_BITS-1:0] r_mem [DEPTH];
    logic [DATA_BITS-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read data holds until the next read, so a stalled consumer keeps it.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

/* src/three_level_priority_job_queue_unit.sv */
// ---------------------------------------------------------------------------
// Three-level priority job queue unit
// Three bounded FIFO queues of job tags served in strict priority order.
// ---------------------------------------------------------------------------
// Each transfer on the job channel is one operation: a push appends job_tag
// to the high, normal or low queue (priority code three goes to normal), a
// pop removes the oldest tag of the highest non-empty queue, and a clear
// empties all three queues. Every operation produces exactly one transfer on
// the result channel, carrying a status (done, push rejected because the
// queue is full, or pop found all queues empty), the popped tag and its level
// (zero unless a pop succeeded), and the total number of pending tags after
// the operation, saturated at 63. The unknown kind code three does nothing
// and reports done. The unit sustains one operation per clock cycle while
// the consumer takes results as they come. The edge of the job transfer
// performs the registered read of the tag memory and loads stage one;
// stage one then moves on into the output register, which drives the
// result channel. The job channel stalls only when both of those stages
// hold results the consumer has not yet taken. The tags of all three
// queues live in one synchronous RAM addressed by level and queue slot;
// pointers and fill counts are small registers, so no clearing pass runs
// after reset and a clear takes effect as soon as it is accepted. Memory
// entries are never read before they are written.
// ---------------------------------------------------------------------------
`default_nettype none

module three_level_priority_job_queue_unit #(
    parameter int QUEUE_DEPTH = 16,
    parameter int TAG_BITS    = 16
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    tpjq_job_if.sink       i_job,
    tpjq_result_if.source  o_result
);
    import tpjq_pkg::*;

    localparam int PTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_BITS   = $clog2(QUEUE_DEPTH + 1);
    // Only the low STORE_BITS bits of a tag, at most 16, ever reach the memory or the result.
    localparam int STORE_BITS = (TAG_BITS < TAG_W) ? TAG_BITS : TAG_W;
    localparam int ADDR_BITS  = LEVEL_W + PTR_BITS;
    localparam int SUM_BITS   = (CNT_BITS + 2 > PENDING_W) ? CNT_BITS + 2 : PENDING_W;
    localparam int NUM_LEVELS = 3;

    // Queue bookkeeping, one entry per level.
    logic [PTR_BITS-1:0] r_rptr [NUM_LEVELS];
    logic [PTR_BITS-1:0] r_wptr [NUM_LEVELS];
    logic [CNT_BITS-1:0] r_cnt  [NUM_LEVELS];
    logic [PTR_BITS-1:0] n_rptr [NUM_LEVELS];
    logic [PTR_BITS-1:0] n_wptr [NUM_LEVELS];
    logic [CNT_BITS-1:0] n_cnt  [NUM_LEVELS];

    // Stage one: operation accepted, tag read in flight.
    logic    r_s1_valid;
    t_status r_s1_status;
    t_level  r_s1_level;
    logic    r_s1_hit;
    logic    n_s1_hit;
    t_status n_s1_status;

    // Output register.
    logic     r_out_valid;
    t_status  r_out_status;
    t_tag     r_out_tag;
    t_level   r_out_level;
    t_pending r_out_pending;

    logic                  accept;
    logic                  s1_go;
    t_level                push_level;
    t_level                pop_level;
    logic                  pop_found;
    logic                  push_full;
    logic                  wr_en;
    logic                  rd_en;
    logic [ADDR_BITS-1:0]  wr_addr;
    logic [ADDR_BITS-1:0]  rd_addr;
    logic [STORE_BITS-1:0] rd_data;
    logic [SUM_BITS-1:0]   pending_sum;
    t_pending              pending_sat;

    // Stage one moves on whenever the output register is free or being taken.
    // A new job is taken only when stage one is empty or moving on, so the
    // RAM read data always belongs to the operation sitting in stage one.
    assign s1_go    = r_s1_valid && (!r_out_valid || o_result.ready);
    assign i_job.ready = !r_s1_valid || s1_go;
    assign accept   = i_job.valid && i_job.ready;

    // Priority code three maps to the normal queue.
    always_comb begin
        case (i_job.priority_req)
            LEVEL_HIGH: push_level = LEVEL_HIGH;
            LEVEL_LOW:  push_level = LEVEL_LOW;
            default:    push_level = LEVEL_NORMAL;
        endcase
    end

    assign push_full = (r_cnt[push_level] == CNT_BITS'(QUEUE_DEPTH));

    // Strict priority: the first non-empty level wins.
    always_comb begin
        pop_found = 1'b1;
        if (r_cnt[LEVEL_HIGH] != '0) begin
            pop_level = LEVEL_HIGH;
        end else if (r_cnt[LEVEL_NORMAL] != '0) begin
            pop_level = LEVEL_NORMAL;
        end else if (r_cnt[LEVEL_LOW] != '0) begin
            pop_level = LEVEL_LOW;
        end else begin
            pop_level = LEVEL_HIGH;
            pop_found = 1'b0;
        end
    end

    always_comb begin
        n_rptr      = r_rptr;
        n_wptr      = r_wptr;
        n_cnt       = r_cnt;
        n_s1_hit    = 1'b0;
        n_s1_status = STATUS_DONE;
        wr_en       = 1'b0;
        rd_en       = 1'b0;
        case (i_job.kind)
            KIND_PUSH: begin
                if (push_full) begin
                    n_s1_status = STATUS_FULL;
                end else begin
                    wr_en              = accept;
                    n_wptr[push_level] = (r_wptr[push_level] == PTR_BITS'(QUEUE_DEPTH - 1))
                                         ? '0 : r_wptr[push_level] + 1'b1;
                    n_cnt[push_level]  = r_cnt[push_level] + 1'b1;
                end
            end
            KIND_POP: begin
                if (pop_found) begin
                    rd_en             = accept;
                    n_s1_hit          = 1'b1;
                    n_rptr[pop_level] = (r_rptr[pop_level] == PTR_BITS'(QUEUE_DEPTH - 1))
                                        ? '0 : r_rptr[pop_level] + 1'b1;
                    n_cnt[pop_level]  = r_cnt[pop_level] - 1'b1;
                end else begin
                    n_s1_status = STATUS_EMPTY;
                end
            end
            KIND_CLEAR: begin
                for (int i = 0; i < NUM_LEVELS; i++) begin
                    n_rptr[i] = '0;
                    n_wptr[i] = '0;
                    n_cnt[i]  = '0;
                end
            end
            default: begin
                // Unused kind code: no change, reported as done.
            end
        endcase
    end

    assign wr_addr = {push_level, r_wptr[push_level]};
    assign rd_addr = {pop_level, r_rptr[pop_level]};

    tpjq_tag_ram #(
        .ADDR_BITS (ADDR_BITS),
        .DATA_BITS (STORE_BITS)
    ) u_tag_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (i_job.job_tag[STORE_BITS-1:0]),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_LEVELS; i++) begin
                r_rptr[i] <= '0;
                r_wptr[i] <= '0;
                r_cnt[i]  <= '0;
            end
        end else if (accept) begin
            r_rptr <= n_rptr;
            r_wptr <= n_wptr;
            r_cnt  <= n_cnt;
        end
    end

    // While stage one holds an operation no newer one has been taken, so the
    // fill counts are exactly those left behind by that operation.
    assign pending_sum = SUM_BITS'(r_cnt[LEVEL_HIGH]) + SUM_BITS'(r_cnt[LEVEL_NORMAL])
                       + SUM_BITS'(r_cnt[LEVEL_LOW]);
    assign pending_sat = (pending_sum > SUM_BITS'(PENDING_MAX))
                         ? PENDING_MAX : pending_sum[PENDING_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_go) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_status <= n_s1_status;
            r_s1_level  <= pop_level;
            r_s1_hit    <= n_s1_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_go) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go) begin
            r_out_status  <= r_s1_status;
            r_out_tag     <= r_s1_hit ? TAG_W'(rd_data) : '0;
            r_out_level   <= r_s1_hit ? r_s1_level : LEVEL_HIGH;
            r_out_pending <= pending_sat;
        end
    end

    assign o_result.valid         = r_out_valid;
    assign o_result.status        = r_out_status;
    assign o_result.popped_tag    = r_out_tag;
    assign o_result.popped_level  = r_out_level;
    assign o_result.pending_count = r_out_pending;

endmodule

`default_nettype wire

/* src/tpjq_checker.sv */
// ---------------------------------------------------------------------------
// Three-level priority job queue: port checker
// Watches the result channel of the unit and is bound to its top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "three_level_priority_job_queue_unit_defines.svh"

module tpjq_checker (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                i_out_valid,
    input wire logic                i_out_ready,
    input wire tpjq_pkg::t_status   i_status,
    input wire tpjq_pkg::t_tag      i_popped_tag,
    input wire tpjq_pkg::t_level    i_popped_level,
    input wire tpjq_pkg::t_pending  i_pending_count
);
    import tpjq_pkg::*;

    // A result that is not taken stays on the port unchanged.
    `TPJQ_ASSERT_NEXT(a_result_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_status) && $stable(i_popped_tag) && $stable(i_popped_level) && $stable(i_pending_count), "result changed while stalled")

    // A failed operation carries no tag and no level.
    `TPJQ_ASSERT_SAME(a_no_pop_fields, i_clk, i_rst_n, i_out_valid && (i_status != STATUS_DONE), (i_popped_tag == '0) && (i_popped_level == LEVEL_HIGH), "failed operation carries pop fields")

    // A pop that found nothing means every queue was empty.
    `TPJQ_ASSERT_SAME(a_empty_count, i_clk, i_rst_n, i_out_valid && (i_status == STATUS_EMPTY), i_pending_count == '0, "empty pop with tags pending")

    // Popped level and status are always legal codes.
    `TPJQ_ASSERT_SAME(a_legal_codes, i_clk, i_rst_n, i_out_valid, (i_popped_level <= LEVEL_LOW) && (i_status <= STATUS_EMPTY), "illegal level or status code")

endmodule

bind three_level_priority_job_queue_unit tpjq_checker u_tpjq_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_out_valid     (o_result.valid),
    .i_out_ready     (o_result.ready),
    .i_status        (o_result.status),
    .i_popped_tag    (o_result.popped_tag),
    .i_popped_level  (o_result.popped_level),
    .i_pending_count (o_result.pending_count)
);

`default_nettype wire

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Three-level priority job queue unit: testbench
// Drives push, pop, clear and unused operations over the job channel, keeps
// its own model of the three queues, and checks every result transfer
// against the expected status, popped tag, popped level and pending total.
// ---------------------------------------------------------------------------

module testbench;
    import tpjq_pkg::*;

    localparam int QUEUE_DEPTH = 16;
    localparam int CYCLE_LIMIT = 100000;
    localparam int TAIL_CYCLES = 8;

    // The package names three operations; code three does nothing.
    localparam t_kind KIND_UNUSED = 2'd3;
    // Priority code three is served by the normal queue.
    localparam t_level LEVEL_CODE_THREE = 2'd3;

    typedef struct packed {
        t_status  status;
        t_tag     popped_tag;
        t_level   popped_level;
        t_pending pending_count;
    } t_job_result;

    logic clk = 1'b0;
    logic rst_n;

    // When set, neither side idles or stalls.
    bit steady = 1'b0;
    int error_count = 0;
    int cycle_count = 0;

    tpjq_job_if    job_ch ();
    tpjq_result_if res_ch ();

    // Model state: tags waiting in each priority queue, oldest first.
    t_tag level_fifo[3][$];
    t_job_result expected_results[$];

    three_level_priority_job_queue_unit #(
        .QUEUE_DEPTH(QUEUE_DEPTH),
        .TAG_BITS   (TAG_W)
    ) u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_job   (job_ch),
        .o_result(res_ch)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // The result consumer stalls at random except during the steady stretch.
    always @(posedge clk) begin
        res_ch.ready <= steady || ($urandom_range(0, 99) >= 38);
    end

    // Applies one operation to the queue model and returns what the unit
    // should report for it.
    function automatic t_job_result apply_job(t_kind k, t_tag tag, t_level prio);
        t_job_result r;
        t_level      lvl;
        int          total;
        bit          found;

        r.status       = STATUS_DONE;
        r.popped_tag   = '0;
        r.popped_level = LEVEL_HIGH;
        found          = 1'b0;
        case (k)
            KIND_PUSH: begin
                if (prio == LEVEL_HIGH) lvl = LEVEL_HIGH;
                else if (prio == LEVEL_LOW) lvl = LEVEL_LOW;
                else lvl = LEVEL_NORMAL;
                if (level_fifo[lvl].size() >= QUEUE_DEPTH) r.status = STATUS_FULL;
                else level_fifo[lvl].insert(level_fifo[lvl].size(), tag);
            end
            KIND_POP: begin
                r.status = STATUS_EMPTY;
                for (int lv = 0; lv < 3; lv++) begin
                    if (!found && level_fifo[lv].size() != 0) begin
                        found          = 1'b1;
                        r.popped_tag   = level_fifo[lv][0];
                        level_fifo[lv].delete(0);
                        r.popped_level = t_level'(lv);
                        r.status       = STATUS_DONE;
                    end
                end
            end
            KIND_CLEAR: begin
                for (int lv = 0; lv < 3; lv++) level_fifo[lv].delete();
            end
            default: begin
            end
        endcase
        total = level_fifo[0].size() + level_fifo[1].size() + level_fifo[2].size();
        r.pending_count = (total > int'(PENDING_MAX)) ? PENDING_MAX : t_pending'(total);
        return r;
    endfunction

    // Result checking first, then prediction for a job accepted at this edge.
    // The unit registers each result before it reaches the result channel, so the order cannot matter.
    always @(posedge clk) begin : result_check
        t_job_result want;

        if (rst_n) begin
            if (res_ch.valid && res_ch.ready) begin
                if (expected_results.size() == 0) begin
                    $error("result transfer with nothing expected: status %0d tag %0h",
                           res_ch.status, res_ch.popped_tag);
                    error_count++;
                end else begin
                    want = expected_results[0];
                    expected_results.delete(0);
                    if (res_ch.status !== want.status) begin
                        $error("status: expected %0d, actual %0d",
                               want.status, res_ch.status);
                        error_count++;
                    end
                    if (res_ch.popped_tag !== want.popped_tag) begin
                        $error("popped_tag: expected %0h, actual %0h",
                               want.popped_tag, res_ch.popped_tag);
                        error_count++;
                    end
                    if (res_ch.popped_level !== want.popped_level) begin
                        $error("popped_level: expected %0d, actual %0d",
                               want.popped_level, res_ch.popped_level);
                        error_count++;
                    end
                    if (res_ch.pending_count !== want.pending_count) begin
                        $error("pending_count: expected %0d, actual %0d",
                               want.pending_count, res_ch.pending_count);
                        error_count++;
                    end
                end
            end
            if (job_ch.valid && job_ch.ready) begin
                expected_results.insert(expected_results.size(),
                    apply_job(job_ch.kind, job_ch.job_tag, job_ch.priority_req));
            end
        end
    end

    // Called at a rising edge; returns at the edge where the transfer happens.
    // Idle cycles are inserted before the item at random.
    task automatic send_job(t_kind k, t_tag tag, t_level prio);
        while (!steady && $urandom_range(0, 99) < 38) begin
            job_ch.valid <= 1'b0;
            @(posedge clk);
        end
        job_ch.valid        <= 1'b1;
        job_ch.kind         <= k;
        job_ch.job_tag      <= tag;
        job_ch.priority_req <= prio;
        do @(posedge clk); while (!job_ch.ready);
    endtask

    task automatic test_empty_and_unused();
        send_job(KIND_POP, 16'h1234, LEVEL_LOW);
        send_job(KIND_UNUSED, 16'hFFFF, LEVEL_CODE_THREE);
        send_job(KIND_CLEAR, 16'h0000, LEVEL_HIGH);
    endtask

    // One tag per priority code, then pops drain them in strict priority
    // order; the code-three push lands behind the normal one.
    task automatic test_priority_order();
        send_job(KIND_PUSH, 16'hA5A5, LEVEL_LOW);
        send_job(KIND_PUSH, 16'h0000, LEVEL_NORMAL);
        send_job(KIND_PUSH, 16'h5A5A, LEVEL_CODE_THREE);
        send_job(KIND_PUSH, 16'hFFFF, LEVEL_HIGH);
        send_job(KIND_UNUSED, 16'h8001, LEVEL_HIGH);
        repeat (5) send_job(KIND_POP, 16'hFFFF, LEVEL_CODE_THREE);
    endtask

    task automatic test_clear();
        send_job(KIND_PUSH, 16'h8000, LEVEL_HIGH);
        send_job(KIND_PUSH, 16'h0001, LEVEL_LOW);
        send_job(KIND_CLEAR, 16'hFFFF, LEVEL_CODE_THREE);
        send_job(KIND_POP, 16'h0000, LEVEL_HIGH);
    endtask

    // Fill one queue to the brim and push once more: the extra tag is refused.
    task automatic test_overflow();
        repeat (QUEUE_DEPTH + 1) send_job(KIND_PUSH, t_tag'($urandom), LEVEL_LOW);
        send_job(KIND_POP, t_tag'($urandom), LEVEL_HIGH);
        send_job(KIND_PUSH, 16'hC3C3, LEVEL_LOW);
        send_job(KIND_CLEAR, t_tag'($urandom), LEVEL_NORMAL);
    endtask

    // Phases with different push/pop balance so that the queues run from
    // empty to full and back. Clears and the unused code stay rare, or the
    // queues would never fill.
    task automatic test_random_traffic();
        int    push_pct[9] = '{55, 80, 35, 90, 50, 20, 70, 85, 45};
        int    pick;
        t_kind k;

        for (int ph = 0; ph < 9; ph++) begin
            steady = (ph == 3);
            for (int n = 0; n < 150; n++) begin
                pick = $urandom_range(0, 99);
                if (pick < push_pct[ph]) k = KIND_PUSH;
                else if (pick < push_pct[ph] + 2) k = KIND_UNUSED;
                else if (pick < push_pct[ph] + 3) k = KIND_CLEAR;
                else k = KIND_POP;
                send_job(k, t_tag'($urandom), t_level'($urandom_range(0, 3)));
            end
        end
        steady = 1'b0;
    endtask

    initial begin
        rst_n               <= 1'b0;
        job_ch.valid        <= 1'b0;
        job_ch.kind         <= KIND_PUSH;
        job_ch.job_tag      <= '0;
        job_ch.priority_req <= LEVEL_HIGH;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        test_empty_and_unused();
        test_priority_order();
        test_clear();
        test_overflow();
        test_random_traffic();

        job_ch.valid <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0) @(posedge clk);
        // Wait on so that a spurious extra result would be seen.
        repeat (TAIL_CYCLES) @(posedge clk);

        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
